// ----- hdl/kdar_pkg.sv -----
// types and constants shared by the keypad debounce / auto-repeat block
// no dependencies; imported by kdar_scan and the top level
package kdar_pkg;

  localparam int NUM_BTN     = 4;
  localparam int CODE_W      = 8;
  localparam int COUNT_W     = 10;
  localparam int TAG_W       = 2;
  localparam int WORD_W      = 18;
  localparam int PAD_W       = WORD_W - TAG_W - CODE_W;
  localparam int ENTRY_W     = TAG_W + CODE_W;
  localparam int LEVEL_W     = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int NUM_BANK    = 4;
  localparam int BANK_SEL_W  = 2;
  localparam int OQ_DEPTH    = 3;
  localparam int OQ_IDX_W    = 2;

  localparam logic [COUNT_W-1:0] ARM_COUNT  = 10'd2;
  localparam logic [COUNT_W-1:0] LONG_COUNT = 10'd200;
  localparam logic [COUNT_W-1:0] FAST_COUNT = 10'd500;
  localparam logic [COUNT_W-1:0] FOLD_COUNT = 10'd550;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_LONG    = 2'd2
  } mode_e;

  // upper bits of the event word: 0x10000 slow repeat, 0x20000 fast repeat
  typedef enum logic [TAG_W-1:0] {
    TAG_NONE = 2'b00,
    TAG_SLOW = 2'b01,
    TAG_FAST = 2'b10
  } tag_e;

  typedef struct packed {
    logic              vld;
    tag_e              tag;
    logic [CODE_W-1:0] code;
  } evt_t;

  typedef struct packed {
    logic               has;
    logic [WORD_W-1:0]  word;
    logic [LEVEL_W-1:0] level;
    logic               drop;
  } result_t;

  // index add that wraps at the output queue depth
  function automatic logic [OQ_IDX_W-1:0] oq_idx(input logic [OQ_IDX_W-1:0] a,
                                                 input logic [OQ_IDX_W-1:0] b);
    logic [OQ_IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (OQ_IDX_W + 1)'(OQ_DEPTH)) begin
      sum = sum - (OQ_IDX_W + 1)'(OQ_DEPTH);
    end
    return sum[OQ_IDX_W-1:0];
  endfunction

endpackage

// ----- hdl/kdar_scan.sv -----
// per-button debounce and auto-repeat next-state logic for one scan tick
// depends on kdar_pkg
module kdar_scan import kdar_pkg::*; (
  input  logic               held_i,
  input  mode_e              mode_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [CODE_W-1:0]  code_i,
  output mode_e              mode_o,
  output logic [COUNT_W-1:0] count_o,
  output evt_t               evt_o
);

  logic [COUNT_W-1:0] inc;

  always_comb begin
    inc         = count_i + COUNT_W'(1);
    mode_o      = mode_i;
    count_o     = inc;
    evt_o.vld   = 1'b0;
    evt_o.tag   = TAG_NONE;
    evt_o.code  = code_i;
    if (held_i) begin
      case (mode_i)
        MODE_PRESSED: begin
          if (inc >= LONG_COUNT) begin
            mode_o  = MODE_LONG;
            count_o = '0;
          end
        end
        MODE_LONG: begin
          if (inc < FAST_COUNT) begin
            // multiples of 100 below 500
            if (inc inside {10'd0, 10'd100, 10'd200, 10'd300, 10'd400}) begin
              evt_o.vld = 1'b1;
              evt_o.tag = TAG_SLOW;
            end
          end else begin
            // multiples of 50 from 500 up
            if (inc inside {10'd500, 10'd550, 10'd600, 10'd650, 10'd700, 10'd750,
                            10'd800, 10'd850, 10'd900, 10'd950, 10'd1000}) begin
              evt_o.vld = 1'b1;
              evt_o.tag = TAG_FAST;
            end
            if (inc >= FOLD_COUNT) begin
              count_o = FAST_COUNT;
            end
          end
        end
        default: begin
          // idle, and the unused code decodes as idle
          if (inc > ARM_COUNT && inc < LONG_COUNT) begin
            mode_o = MODE_PRESSED;
          end else begin
            mode_o = MODE_IDLE;
          end
        end
      endcase
    end else begin
      // short press reported on release; a zero code gives no event
      if (mode_i == MODE_PRESSED) begin
        evt_o.vld = (code_i != '0);
      end
      mode_o  = MODE_IDLE;
      count_o = '0;
    end
  end

endmodule

// ----- hdl/keypad_debounce_autorepeat_fifo_top.sv -----
// four-button debounce with auto-repeat, event queue in four banked memories
// depends on kdar_pkg and kdar_scan
//
// Use: the s_axis channel carries one item per beat. tuser = 0 is a scan tick,
// tdata[3:0] giving the held buttons; tuser = 1 pops the oldest queued event.
// Every item gives exactly one result beat on m_axis: tuser = has_event, tdata
// holds the event word, the queue level after the item and the dropped flag.
// Configuration writes on the cfg channel (always ready) set the key code of
// button cfg_index_i; indexes beyond 3 are ignored. Write only while idle.
// Throughput is one item per cycle while s_axis_tready is high: a tick may queue
// up to four events at once, one into each memory bank, and a pop is one
// synchronous read. A result passes through the bank read and read-stage
// registers, then into the three-entry result queue that drives m_axis.
// When the receiver stalls, up to three results wait in the result queue and
// s_axis_tready falls until room returns; nothing is lost.
// Reset clears button states, queue pointers and the result queue and loads
// key codes 1..4. The event queue holds FIFO_DEPTH-1 events; an event that
// finds it full is discarded and flagged as dropped.
module keypad_debounce_autorepeat_fifo_top import kdar_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [3:0] pressed_mask
  input  logic                   s_axis_tuser,   // [0] action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [17:0] event_word, [21:18] fifo_level,
                                                 // [22] dropped
  output logic                   m_axis_tuser,   // [0] has_event
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CODE_W-1:0]      cfg_data_i
);

  localparam int CNT_W      = $clog2(FIFO_DEPTH);
  localparam int BANK_ROWS  = (FIFO_DEPTH + NUM_BANK - 1) / NUM_BANK;
  localparam int BANK_AW    = (BANK_ROWS <= 2) ? 1 : $clog2(BANK_ROWS);
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int PTR_W      = BANK_AW + BANK_SEL_W;

  logic [CODE_W-1:0]  code_q  [NUM_BTN];
  mode_e              mode_q  [NUM_BTN];
  logic [COUNT_W-1:0] count_q [NUM_BTN];
  mode_e              mode_n  [NUM_BTN];
  logic [COUNT_W-1:0] count_n [NUM_BTN];
  evt_t               evt     [NUM_BTN];

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic in_fire, is_pop, tick_fire, pop_fire, out_fire;

  // push allocation
  logic [CNT_W-1:0]   run;
  logic [2:0]         rank;
  logic [PTR_W-1:0]   slot;
  logic               drop;
  logic [NUM_BANK-1:0] bank_we;
  logic [BANK_AW-1:0] bank_waddr [NUM_BANK];
  logic [ENTRY_W-1:0] bank_wdata [NUM_BANK];
  logic [ENTRY_W-1:0] bank_rdata_q [NUM_BANK];
  logic [BANK_AW-1:0] raddr;

  // read stage
  logic                  s1_valid_q;
  logic                  s1_has_q;
  logic [BANK_SEL_W-1:0] s1_bank_q;
  logic [LEVEL_W-1:0]    s1_level_q;
  logic                  s1_drop_q;
  logic [ENTRY_W-1:0]    s1_entry;
  result_t               s1_res;

  // result queue
  result_t             oq_q [OQ_DEPTH];
  logic [OQ_IDX_W-1:0] oq_head_q, oq_head_d, oq_tail;
  logic [OQ_IDX_W-1:0] oq_cnt_q, oq_cnt_d;

  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign is_pop    = (s_axis_tuser == ACT_POP);
  assign tick_fire = in_fire & ~is_pop;
  assign pop_fire  = in_fire & is_pop & (cnt_q != '0);
  assign out_fire  = m_axis_tvalid & m_axis_tready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        code_q[b] <= CODE_W'(b + 1);
      end
    end else if (cfg_valid_i && cfg_index_i < CFG_IDX_W'(NUM_BTN)) begin
      code_q[cfg_index_i[1:0]] <= cfg_data_i;
    end
  end

  for (genvar g = 0; g < NUM_BTN; g++) begin : g_btn
    kdar_scan u_scan (
      .held_i  (s_axis_tdata[g]),
      .mode_i  (mode_q[g]),
      .count_i (count_q[g]),
      .code_i  (code_q[g]),
      .mode_o  (mode_n[g]),
      .count_o (count_n[g]),
      .evt_o   (evt[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        mode_q[b]  <= MODE_IDLE;
        count_q[b] <= '0;
      end
    end else if (tick_fire) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        mode_q[b]  <= mode_n[b];
        count_q[b] <= count_n[b];
      end
    end
  end

  // events take consecutive slots in button order; each lands in its own bank
  always_comb begin
    run     = cnt_q;
    rank    = '0;
    slot    = wp_q;
    drop    = 1'b0;
    bank_we = '0;
    for (int k = 0; k < NUM_BANK; k++) begin
      bank_waddr[k] = '0;
      bank_wdata[k] = '0;
    end
    for (int k = 0; k < NUM_BTN; k++) begin
      if (evt[k].vld) begin
        if (run < CNT_W'(FIFO_DEPTH - 1)) begin
          slot = wp_q + PTR_W'(rank);
          bank_we[slot[BANK_SEL_W-1:0]]    = 1'b1;
          bank_waddr[slot[BANK_SEL_W-1:0]] = slot[PTR_W-1:BANK_SEL_W];
          bank_wdata[slot[BANK_SEL_W-1:0]] = {evt[k].tag, evt[k].code};
          run  = run + CNT_W'(1);
          rank = rank + 3'd1;
        end else begin
          drop = 1'b1;
        end
      end
    end
  end

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (tick_fire) begin
      wp_d  = wp_q + PTR_W'(rank);
      cnt_d = run;
    end else if (pop_fire) begin
      rp_d  = rp_q + PTR_W'(1);
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign raddr = rp_q[PTR_W-1:BANK_SEL_W];

  for (genvar g = 0; g < NUM_BANK; g++) begin : g_bank
    logic [ENTRY_W-1:0] mem [BANK_DEPTH];
    always_ff @(posedge clk_i) begin
      if (tick_fire && bank_we[g]) begin
        mem[bank_waddr[g]] <= bank_wdata[g];
      end
      bank_rdata_q[g] <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_has_q   <= pop_fire;
      s1_bank_q  <= rp_q[BANK_SEL_W-1:0];
      s1_level_q <= LEVEL_W'(cnt_d);
      s1_drop_q  <= tick_fire & drop;
    end
  end

  assign s1_entry = bank_rdata_q[s1_bank_q];

  always_comb begin
    s1_res.has   = s1_has_q;
    s1_res.word  = '0;
    s1_res.level = s1_level_q;
    s1_res.drop  = s1_drop_q;
    if (s1_has_q) begin
      s1_res.word = {s1_entry[ENTRY_W-1 -: TAG_W], {PAD_W{1'b0}}, s1_entry[CODE_W-1:0]};
    end
  end

  // result queue: room is reserved for the beat in the read stage
  assign oq_tail       = oq_idx(oq_head_q, oq_cnt_q);
  assign m_axis_tvalid = (oq_cnt_q != '0);
  assign s_axis_tready = ({1'b0, oq_cnt_q} + (OQ_IDX_W + 1)'(s1_valid_q))
                         < (OQ_IDX_W + 1)'(OQ_DEPTH);

  always_comb begin
    oq_head_d = oq_head_q;
    oq_cnt_d  = oq_cnt_q;
    if (out_fire) begin
      oq_head_d = oq_idx(oq_head_q, OQ_IDX_W'(1));
    end
    if (s1_valid_q && !out_fire) begin
      oq_cnt_d = oq_cnt_q + OQ_IDX_W'(1);
    end else if (!s1_valid_q && out_fire) begin
      oq_cnt_d = oq_cnt_q - OQ_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_head_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      oq_head_q <= oq_head_d;
      oq_cnt_q  <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      oq_q[oq_tail] <= s1_res;
    end
  end

  assign m_axis_tuser = oq_q[oq_head_q].has;
  assign m_axis_tdata = {1'b0, oq_q[oq_head_q].drop, oq_q[oq_head_q].level,
                         oq_q[oq_head_q].word};

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH - 1))
    else $error("event queue count above capacity");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) == PTR_W'(cnt_q))
    else $error("queue pointers disagree with count");

  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (oq_cnt_q < OQ_IDX_W'(OQ_DEPTH)) || m_axis_tready)
    else $error("result queue overflow");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("pop did not take one event");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for keypad_debounce_autorepeat_fifo_top
// depends on kdar_pkg and the keypad top level; predicts every result beat in-line
`timescale 1ns / 1ps

module tb_top import kdar_pkg::*; ();

  localparam int EVQ_DEPTH   = 16;
  localparam int SLOW_PERIOD = 100;
  localparam int FAST_PERIOD = 50;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       act;
    logic [3:0] mask;
  } key_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CODE_W-1:0]      cfg_data_i = '0;

  // predictor state
  logic [CODE_W-1:0]  key_code [NUM_BTN];
  mode_e              key_mode [NUM_BTN];
  logic [COUNT_W-1:0] key_count [NUM_BTN];
  logic [WORD_W-1:0]  evq_store [EVQ_DEPTH];
  int                 evq_wr;
  int                 evq_rd;

  key_item_t keypad_items [$];
  result_t   expected_results [$];
  key_item_t cur_item;

  int  src_gap;
  int  rdy_gap;
  bit  steady_tx;
  bit  steady_rx;
  int  mismatches;
  int  unexpected;
  int  n_ticks;
  int  n_pops;
  int  n_popped;
  int  n_slow;
  int  n_fast;
  int  n_drops;

  // random pattern generator state, one run per button
  int   run_left [NUM_BTN];
  logic run_held [NUM_BTN];

  keypad_debounce_autorepeat_fifo_top #(
    .FIFO_DEPTH(EVQ_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [3:0] pressed_mask
    .s_axis_tuser (s_axis_tuser),   // [0] action
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [17:0] event_word, [21:18] fifo_level, [22] dropped
    .m_axis_tuser (m_axis_tuser),   // [0] has_event
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one button scanned on a tick, returns the word it reports (0 if none)
  function automatic logic [WORD_W-1:0] scan_key(input int b, input logic held);
    logic [COUNT_W-1:0] c;
    logic [WORD_W-1:0]  w;
    w = '0;
    c = key_count[b] + COUNT_W'(1);
    if (held) begin
      case (key_mode[b])
        MODE_PRESSED: begin
          if (c >= LONG_COUNT) begin
            key_mode[b] = MODE_LONG;
            c = '0;
          end
        end
        MODE_LONG: begin
          if (c < FAST_COUNT) begin
            if (c % SLOW_PERIOD == 0) w = {TAG_SLOW, {PAD_W{1'b0}}, key_code[b]};
          end else begin
            if (c % FAST_PERIOD == 0) w = {TAG_FAST, {PAD_W{1'b0}}, key_code[b]};
            if (c >= FOLD_COUNT) c = FAST_COUNT;
          end
        end
        default: begin
          key_mode[b] = (c > ARM_COUNT && c < LONG_COUNT) ? MODE_PRESSED : MODE_IDLE;
        end
      endcase
      key_count[b] = c;
    end else begin
      // short press is reported on release
      if (key_mode[b] == MODE_PRESSED) w = {TAG_NONE, {PAD_W{1'b0}}, key_code[b]};
      key_mode[b]  = MODE_IDLE;
      key_count[b] = '0;
    end
    return w;
  endfunction

  task automatic predict_keypad_step(input key_item_t it);
    result_t           r;
    logic [WORD_W-1:0] w;
    int                nxt;
    r = '0;
    if (it.act == ACT_POP) begin
      if (evq_rd != evq_wr) begin
        r.has  = 1'b1;
        r.word = evq_store[evq_rd];
        evq_rd = (evq_rd + 1) % EVQ_DEPTH;
      end
    end else begin
      for (int b = 0; b < NUM_BTN; b++) begin
        w = scan_key(b, it.mask[b]);
        if (w != '0) begin
          nxt = (evq_wr + 1) % EVQ_DEPTH;
          if (nxt == evq_rd) begin
            r.drop = 1'b1;
          end else begin
            evq_store[evq_wr] = w;
            evq_wr = nxt;
          end
        end
      end
    end
    r.level = LEVEL_W'((evq_wr + EVQ_DEPTH - evq_rd) % EVQ_DEPTH);
    expected_results.push_back(r);
  endtask

  // driver: presents queued items, predicts each accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_keypad_step(cur_item);
        if (cur_item.act == ACT_POP) n_pops++;
        else n_ticks++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (keypad_items.size() > 0) begin
          cur_item = keypad_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W-4){1'b0}}, cur_item.mask};
          s_axis_tuser  <= cur_item.act;
          src_gap = pick_gap(steady_tx);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compares each result beat with the oldest prediction
  always @(posedge clk_i) begin
    result_t           exp_r;
    logic [WORD_W-1:0] got_word;
    logic [LEVEL_W-1:0] got_level;
    logic              got_drop;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_word  = m_axis_tdata[WORD_W-1:0];
        got_level = m_axis_tdata[WORD_W +: LEVEL_W];
        got_drop  = m_axis_tdata[WORD_W+LEVEL_W];
        if (expected_results.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= MAX_REPORTS)
            $display("[%0t] unexpected beat: has=%0b word=%05h lvl=%0d drop=%0b",
                     $realtime, m_axis_tuser, got_word, got_level, got_drop);
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tuser !== exp_r.has || got_word !== exp_r.word ||
              got_level !== exp_r.level || got_drop !== exp_r.drop) begin
            mismatches++;
            if (mismatches + unexpected <= MAX_REPORTS) begin
              $display("[%0t] mismatch: exp has=%0b word=%05h lvl=%0d drop=%0b",
                       $realtime, exp_r.has, exp_r.word, exp_r.level, exp_r.drop);
              $display("          got has=%0b word=%05h lvl=%0d drop=%0b",
                       m_axis_tuser, got_word, got_level, got_drop);
            end
          end
          if (exp_r.has) n_popped++;
          if (exp_r.word[WORD_W-1 -: TAG_W] == TAG_SLOW) n_slow++;
          if (exp_r.word[WORD_W-1 -: TAG_W] == TAG_FAST) n_fast++;
          if (exp_r.drop) n_drops++;
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rdy_gap = pick_gap(steady_rx);
      end
    end
  end

  task automatic add_item(input logic act, input logic [3:0] mask);
    key_item_t it;
    it.act  = act;
    it.mask = mask;
    keypad_items.push_back(it);
  endtask

  task automatic add_ticks(input logic [3:0] mask, input int n);
    for (int i = 0; i < n; i++) add_item(ACT_TICK, mask);
  endtask

  task automatic add_pops(input int n);
    for (int i = 0; i < n; i++) add_item(ACT_POP, 4'($urandom_range(0, 15)));
  endtask

  // sender holds off until everything predicted has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (keypad_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_code(input int idx, input logic [CODE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx < NUM_BTN) key_code[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  // per-button runs: mostly short taps, some holds into slow repeat
  task automatic random_chunk(input int ticks, input int pop_pct);
    logic [3:0] mask;
    int         r;
    steady_tx = ($urandom_range(0, 3) == 0);
    steady_rx = ($urandom_range(0, 3) == 0);
    for (int t = 0; t < ticks; t++) begin
      while ($urandom_range(0, 99) < pop_pct) add_pops(1);
      for (int b = 0; b < NUM_BTN; b++) begin
        if (run_left[b] == 0) begin
          run_held[b] = ~run_held[b];
          r = $urandom_range(0, 99);
          if (!run_held[b]) run_left[b] = $urandom_range(1, 6);
          else if (r < 80) run_left[b] = $urandom_range(1, 12);
          else if (r < 96) run_left[b] = $urandom_range(190, 330);
          else run_left[b] = $urandom_range(480, 560);
        end
        mask[b] = run_held[b];
        run_left[b]--;
      end
      add_item(ACT_TICK, mask);
    end
    wait_drained();
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  initial begin
    int deep_btn;
    for (int b = 0; b < NUM_BTN; b++) begin
      key_code[b]  = CODE_W'(b + 1);
      key_mode[b]  = MODE_IDLE;
      key_count[b] = '0;
      run_left[b]  = 0;
      run_held[b]  = 1'b1;
    end
    evq_wr = 0;
    evq_rd = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty pop, short presses, all four at once, press too short to arm
    add_item(ACT_POP, 4'hf);
    add_ticks(4'h1, 3);
    add_ticks(4'h0, 1);
    add_pops(1);
    add_ticks(4'hf, 3);
    add_ticks(4'h0, 1);
    add_pops(5);
    add_ticks(4'h2, 2);
    add_ticks(4'h0, 1);
    add_pops(1);
    wait_drained();

    // extreme codes; a zero code makes a zero short-press word that is never queued
    write_code(0, 8'h00);
    write_code(1, 8'hff);
    write_code(2, 8'h5a);
    write_code(3, 8'ha5);
    write_code(9, 8'h77);
    add_ticks(4'h3, 3);
    add_ticks(4'h0, 1);
    add_pops(2);
    wait_drained();

    // one button held long enough for slow and fast repeats and the fold back to the fast count
    deep_btn = $urandom_range(0, NUM_BTN - 1);
    run_held[deep_btn] = 1'b1;
    run_left[deep_btn] = 760;
    random_chunk(100, 12);
    random_chunk(100, 3);
    random_chunk(100, 25);
    random_chunk(100, 10);
    random_chunk(100, 5);

    for (int b = 0; b < NUM_BTN; b++) write_code(b, CODE_W'($urandom_range(0, 255)));
    write_code($urandom_range(0, NUM_BTN - 1), 8'h00);
    random_chunk(90, 12);
    random_chunk(90, 3);
    random_chunk(90, 10);

    repeat (20) @(posedge clk_i);
    if (expected_results.size() > 0)
      $display("%0d predicted result beats never arrived", expected_results.size());
    $display("covered %0d ticks and %0d pops: %0d events popped, %0d slow and %0d fast repeats",
             n_ticks, n_pops, n_popped, n_slow, n_fast);
    $display("%0d ticks lost events to a full queue; %0d mismatches, %0d unexpected beats",
             n_drops, mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d items pending", keypad_items.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/kdar_pkg.sv
hdl/kdar_scan.sv
hdl/keypad_debounce_autorepeat_fifo_top.sv
tb/tb_top.sv
